[rtl/avt_pkg.sv]
// Shared types and constants for the affine vertex transform.
// Beat structs, coefficient layout, register indexes and arithmetic widths.
// No dependencies.
`default_nettype none

package avt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_ROWS   = 3;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [CFG_W-1:0] RST_ROW0_PAIR = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_ROW0_ZS   = 64'h0;
    localparam logic [CFG_W-1:0] RST_ROW1_PAIR = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_ROW1_ZS   = 64'h0;
    localparam logic [CFG_W-1:0] RST_ROW2_PAIR = 64'h0;
    localparam logic [CFG_W-1:0] RST_ROW2_ZS   = 64'h0001_0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_PAIR = 3'd0,
        REG_ROW0_ZS   = 3'd1,
        REG_ROW1_PAIR = 3'd2,
        REG_ROW1_ZS   = 3'd3,
        REG_ROW2_PAIR = 3'd4,
        REG_ROW2_ZS   = 3'd5,
        REG_APPLY     = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
        logic signed [COORD_W-1:0] in_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      clipped;
    } out_beat_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] tr;
    } row_coef_t;

    typedef struct packed {
        logic load_prod;
        logic load_out;
    } row_ctl_t;

endpackage

`default_nettype wire

[rtl/avt_cfg_regs.sv]
// Configuration register file for the affine vertex transform.
// Holds the 3x4 matrix and the translation enable; depends on avt_pkg.
`default_nettype none

module avt_cfg_regs
    import avt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output row_coef_t [NUM_ROWS-1:0]  coef,
    output logic                      apply_tr
);

    logic [CFG_W-1:0] row0_pair_reg;
    logic [CFG_W-1:0] row0_zs_reg;
    logic [CFG_W-1:0] row1_pair_reg;
    logic [CFG_W-1:0] row1_zs_reg;
    logic [CFG_W-1:0] row2_pair_reg;
    logic [CFG_W-1:0] row2_zs_reg;
    logic             apply_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_pair_reg <= RST_ROW0_PAIR;
            row0_zs_reg   <= RST_ROW0_ZS;
            row1_pair_reg <= RST_ROW1_PAIR;
            row1_zs_reg   <= RST_ROW1_ZS;
            row2_pair_reg <= RST_ROW2_PAIR;
            row2_zs_reg   <= RST_ROW2_ZS;
            apply_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0_PAIR: row0_pair_reg <= cfg_data;
                REG_ROW0_ZS:   row0_zs_reg   <= cfg_data;
                REG_ROW1_PAIR: row1_pair_reg <= cfg_data;
                REG_ROW1_ZS:   row1_zs_reg   <= cfg_data;
                REG_ROW2_PAIR: row2_pair_reg <= cfg_data;
                REG_ROW2_ZS:   row2_zs_reg   <= cfg_data;
                REG_APPLY:     apply_reg     <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign coef[0] = '{cx: row0_pair_reg[63:32], cy: row0_pair_reg[31:0],
                       cz: row0_zs_reg[63:32],   tr: row0_zs_reg[31:0]};
    assign coef[1] = '{cx: row1_pair_reg[63:32], cy: row1_pair_reg[31:0],
                       cz: row1_zs_reg[63:32],   tr: row1_zs_reg[31:0]};
    assign coef[2] = '{cx: row2_pair_reg[63:32], cy: row2_pair_reg[31:0],
                       cz: row2_zs_reg[63:32],   tr: row2_zs_reg[31:0]};
    assign apply_tr = apply_reg;

endmodule

`default_nettype wire

[rtl/avt_row_lane.sv]
// One output row: three registered products, then sum, round and saturate.
// Depends on avt_pkg; stage enables come from the top level.
`default_nettype none

module avt_row_lane
    import avt_pkg::*;
(
    input  wire logic                      clk,
    input  wire row_ctl_t                  ctl,
    input  wire logic signed [COORD_W-1:0] x,
    input  wire logic signed [COORD_W-1:0] y,
    input  wire logic signed [COORD_W-1:0] z,
    input  wire row_coef_t                 coef,
    input  wire logic                      apply_tr,
    output logic signed [COORD_W-1:0]      result,
    output logic                           clip
);

    logic signed [PROD_W-1:0]  px_next, py_next, pz_next;
    logic signed [PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic signed [COORD_W-1:0] tr_next, tr_reg;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   rnd;
    logic                      pos_ovf, neg_ovf;
    logic signed [COORD_W-1:0] result_next, result_reg;
    logic                      clip_next, clip_reg;

    assign px_next = coef.cx * x;
    assign py_next = coef.cy * y;
    assign pz_next = coef.cz * z;
    assign tr_next = apply_tr ? coef.tr : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            tr_reg <= tr_next;
        end
    end

    assign sum = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(pz_reg)
               + (ACC_W'(tr_reg) <<< FRAC_BITS) + ROUND_HALF;
    assign rnd = sum >>> FRAC_BITS;

    assign pos_ovf = !rnd[ACC_W-1] && (|rnd[ACC_W-2:COORD_W-1]);
    assign neg_ovf = rnd[ACC_W-1] && !(&rnd[ACC_W-2:COORD_W-1]);

    always_comb
    begin
        clip_next = pos_ovf || neg_ovf;
        if (pos_ovf)
            result_next = COORD_MAX;
        else if (neg_ovf)
            result_next = COORD_MIN;
        else
            result_next = rnd[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            result_reg <= result_next;
            clip_reg   <= clip_next;
        end
    end

    assign result = result_reg;
    assign clip   = clip_reg;

endmodule

`default_nettype wire

[rtl/affine_vertex_transform.sv]
// Affine vertex transform top level: input register, three row lanes, control.
// Depends on avt_pkg, avt_cfg_regs and avt_row_lane.
//
// Usage:
//   in_valid/in_ready/in_data carry one point (in_x, in_y, in_z) per beat;
//   out_valid/out_ready/out_data carry the transformed point and the clipped
//   flag. A beat is taken when valid and ready are both high at a clock edge.
//   Each output is the row dot product plus the optional translation, rounded
//   to nearest (halves up) and saturated to 32 bits.
//   An accepted point passes through the input register, the product register
//   and the result register before it shows on out_data.
//   Throughput: one point per cycle unless out_ready stalls the three-stage
//   pipeline; nine 32x32 multipliers work in parallel in the product stage.
//   The cfg port (cfg_we, cfg_index, cfg_data) writes one register per cycle;
//   write it only while the pipeline is empty. Indexes beyond the list are
//   ignored.
//   Reset loads the identity matrix with translation enabled and empties the
//   pipeline. When out_ready is low the pipeline fills its bubbles and then
//   holds; in_ready drops only once every stage is occupied.
`default_nettype none

module affine_vertex_transform
    import avt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_beat_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_beat_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    row_coef_t [NUM_ROWS-1:0]   coef;
    logic                       apply_tr;
    logic                       v1_reg, v2_reg, v3_reg;
    logic                       rdy1, rdy2, rdy3;
    logic                       load_in;
    row_ctl_t                   ctl;
    in_beat_t                   pt_reg;
    logic signed [COORD_W-1:0]  res [NUM_ROWS];
    logic [NUM_ROWS-1:0]        clip;

    avt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .apply_tr  (apply_tr)
    );

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign load_in  = in_valid && rdy1;

    assign ctl.load_prod = v1_reg && rdy2;
    assign ctl.load_out  = v2_reg && rdy3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
            pt_reg <= in_data;
    end

    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        avt_row_lane u_lane (
            .clk      (clk),
            .ctl      (ctl),
            .x        (pt_reg.in_x),
            .y        (pt_reg.in_y),
            .z        (pt_reg.in_z),
            .coef     (coef[r]),
            .apply_tr (apply_tr),
            .result   (res[r]),
            .clip     (clip[r])
        );
    end

    assign out_valid        = v3_reg;
    assign out_data.out_x   = res[0];
    assign out_data.out_y   = res[1];
    assign out_data.out_z   = res[2];
    assign out_data.clipped = |clip;

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty result stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted beat lost from input register");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !v2_reg |=> !out_valid)
        else $error("result repeated after delivery");

    a_clip_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.clipped |->
            (out_data.out_x == COORD_MAX || out_data.out_x == COORD_MIN ||
             out_data.out_y == COORD_MAX || out_data.out_y == COORD_MIN ||
             out_data.out_z == COORD_MAX || out_data.out_z == COORD_MIN))
        else $error("clipped flag without a saturated coordinate");

endmodule

`default_nettype wire
